@@ hw/rtl/csmb_pkg.sv @@
// Shared constants, types and face geometry for the cube-sphere mesh builder.
package csmb_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_RESOLUTION = 32;
    localparam int MAX_VERTICES   = 8192;
    localparam int IDX_W          = 13;
    localparam int POS_W          = 26;
    localparam int KEY_W          = 24;
    localparam int CNT_W          = 14;
    localparam int N2_W           = 20;
    localparam int ROOT_W         = 26;
    localparam int SQRT_STEPS     = 10 + FRAC_BITS;
    localparam int DIV_STEPS      = 2 * FRAC_BITS + 8;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;
    localparam logic CMD_POINT     = 1'b0;
    localparam logic CMD_CLEAR     = 1'b1;

    localparam logic REG_RESOLUTION = 1'b0;
    localparam logic REG_RADIUS     = 1'b1;

    typedef logic signed [7:0] coord_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Cube point from the up term and the two in-face terms of one face.
    function automatic point_t face_point(logic [2:0] face, coord_t tu, coord_t ta, coord_t tb);
        point_t p;
        case (face)
            3'd0:    p = '{x: ta,  y: tu,  z: -tb};
            3'd1:    p = '{x: -ta, y: -tu, z: -tb};
            3'd2:    p = '{x: -tu, y: -tb, z: -ta};
            3'd3:    p = '{x: tu,  y: -tb, z: ta};
            3'd4:    p = '{x: -tb, y: ta,  z: tu};
            3'd5:    p = '{x: -tb, y: -ta, z: -tu};
            default: p = '{x: '0,  y: '0,  z: '0};
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/cube_sphere_mesh_builder.sv @@
// Cube-sphere mesh builder: grid point to sphere vertex, key dedup and triangles.
// One request is taken at a time. Each corner of a point runs through a shared
// sequencer: a setup step, a bit-pair square root, then per axis a restoring
// divide and the MUL1 to MUL4 steps on the one shared multiplier, a key search
// that compares the stored vertices in order, and an advance step. A hit ends
// the search; a miss appends the key when the table has room and emits a vertex
// record. Edge points have one corner, interior points four plus two triangle
// records. A stalled result output holds the sequencer in its emit step. A clear
// or a face code above 5 is handled in the idle state. The key table has one
// write port and one read port and needs no clearing pass: only entries below
// the vertex count are ever compared.
module cube_sphere_mesh_builder
    import csmb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    pt_valid,
    output logic                    pt_stall,
    input  logic                    cmd,
    input  logic [2:0]              face,
    input  logic [4:0]              grid_x,
    input  logic [4:0]              grid_y,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic                    kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic [IDX_W-1:0]        index_a,
    output logic [IDX_W-1:0]        index_b,
    output logic [IDX_W-1:0]        index_c,
    output logic                    table_full,
    output logic                    last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_MUL3  = 4'd7;
    localparam logic [3:0] S_MUL4  = 4'd8;
    localparam logic [3:0] S_SRCH  = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;
    localparam logic [3:0] S_MISS  = 4'd11;
    localparam logic [3:0] S_EMITV = 4'd12;
    localparam logic [3:0] S_NEXT  = 4'd13;
    localparam logic [3:0] S_TRI1  = 4'd14;
    localparam logic [3:0] S_TRI2  = 4'd15;

    localparam int DIVD_W = DIV_STEPS;
    localparam int REM_W  = ROOT_W + 4;

    logic [3:0]             state_reg;
    logic [5:0]             resolution_reg;
    logic [15:0]            radius_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       addr_reg;

    logic [2:0]             face_reg;
    logic [4:0]             gx_reg;
    logic [4:0]             gy_reg;
    logic [5:0]             r_reg;
    logic                   interior_reg;
    logic [1:0]             corner_reg;
    logic [1:0]             comp_reg;

    coord_t                 p_reg [3];
    pos_t                   pos_reg [3];
    key_t                   key_reg [3];
    idx_t                   idx_reg [4];
    logic [3:0]             full_reg;

    logic [N2_W-1:0]        n2s_reg;
    logic [REM_W-1:0]       srem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [ROOT_W-1:0]      len_reg;
    logic [5:0]             step_reg;

    logic [DIVD_W-1:0]      divd_reg;
    logic [ROOT_W+1:0]      drem_reg;
    logic [17:0]            q_reg;
    logic [33:0]            prod_reg;
    logic [24:0]            pm_reg;
    logic                   neg_reg;

    logic [3*KEY_W-1:0]     key_mem [MAX_VERTICES];
    logic [3*KEY_W-1:0]     rd_reg;

    logic                   res_valid_reg;
    logic                   kind_reg;
    pos_t                   out_pos_reg [3];
    idx_t                   out_a_reg;
    idx_t                   out_b_reg;
    idx_t                   out_c_reg;
    logic                   out_full_reg;
    logic                   out_last_reg;

    logic                   accept;
    logic                   out_free;
    logic                   emit;
    logic [5:0]             r_clamp;
    logic [5:0]             d_clamp;
    logic [5:0]             cx;
    logic [5:0]             cy;
    coord_t                 tu;
    coord_t                 ta;
    coord_t                 tb;
    point_t                 pt;
    logic signed [15:0]     sqx;
    logic signed [15:0]     sqy;
    logic signed [15:0]     sqz;
    logic [N2_W-1:0]        n2;
    logic [REM_W-1:0]       srem_sh;
    logic [REM_W-1:0]       strial;
    logic [ROOT_W+1:0]      drem_sh;
    logic [ROOT_W+1:0]      dvsr;
    coord_t                 pc;
    logic [7:0]             pc_abs;
    logic [24:0]            mul_a;
    logic [15:0]            mul_b;
    logic [40:0]            mul_out;
    logic [33:0]            pm_sum;
    logic [33:0]            km_sum;
    logic [KEY_W-1:0]       km_ext;
    logic [POS_W-1:0]       pm_ext;
    logic                   mem_we;
    logic                   key_hit;

    assign accept    = pt_valid && !pt_stall;
    assign pt_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !res_valid_reg || !res_stall;
    assign emit      = out_free && (state_reg inside {S_EMITV, S_TRI1, S_TRI2});

    always_comb
    begin
        if (resolution_reg < 6'd2)
            r_clamp = 6'd2;
        else if (resolution_reg > 6'(MAX_RESOLUTION))
            r_clamp = 6'(MAX_RESOLUTION);
        else
            r_clamp = resolution_reg;
        d_clamp = r_clamp - 6'd1;
    end

    // Cube point of the current corner and its squared length.
    always_comb
    begin
        cx  = {1'b0, gx_reg} + {5'd0, corner_reg[0]};
        cy  = {1'b0, gy_reg} + {5'd0, corner_reg[1]};
        tu  = coord_t'({2'b00, r_reg} - 8'd1);
        ta  = coord_t'({1'b0, cx, 1'b0} - {2'b00, r_reg} + 8'd1);
        tb  = coord_t'({1'b0, cy, 1'b0} - {2'b00, r_reg} + 8'd1);
        pt  = face_point(face_reg, tu, ta, tb);
        sqx = pt.x * pt.x;
        sqy = pt.y * pt.y;
        sqz = pt.z * pt.z;
        n2  = N2_W'(16'(sqx)) + N2_W'(16'(sqy)) + N2_W'(16'(sqz));
    end

    always_comb
    begin
        srem_sh = {srem_reg[REM_W-3:0], n2s_reg[N2_W-1:N2_W-2]};
        strial  = REM_W'({root_reg, 2'b01});
        drem_sh = {drem_reg[ROOT_W:0], divd_reg[DIVD_W-1]};
        dvsr    = {1'b0, len_reg, 1'b0};
        pc      = p_reg[comp_reg];
        pc_abs  = pc[7] ? 8'(-pc) : pc;
    end

    // Shared multiplier: quotient times radius, then position times 4R.
    always_comb
    begin
        if (state_reg == S_MUL3)
        begin
            mul_a = pm_reg;
            mul_b = {8'd0, r_reg, 2'b00};
        end
        else
        begin
            mul_a = {7'd0, q_reg};
            mul_b = radius_reg;
        end
        mul_out = 41'(mul_a) * 41'(mul_b);
        pm_sum  = prod_reg + 34'd128;
        km_sum  = prod_reg + 34'(1 << (FRAC_BITS - 1));
        km_ext  = {7'd0, km_sum[FRAC_BITS +: 17]};
        pm_ext  = {1'b0, pm_reg};
    end

    assign key_hit = (rd_reg == {key_reg[0], key_reg[1], key_reg[2]});
    assign mem_we  = (state_reg == S_MISS) && (count_reg < CNT_W'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[count_reg[IDX_W-1:0]] <= {key_reg[0], key_reg[1], key_reg[2]};
        rd_reg <= key_mem[addr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= 6'd16;
            radius_reg     <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_RESOLUTION)
                resolution_reg <= cfg_data[5:0];
            else
                radius_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == CMD_CLEAR)
                            count_reg <= '0;
                        else if (face <= 3'd5)
                        begin
                            face_reg     <= face;
                            r_reg        <= r_clamp;
                            gx_reg       <= ({1'b0, grid_x} > d_clamp) ? d_clamp[4:0] : grid_x;
                            gy_reg       <= ({1'b0, grid_y} > d_clamp) ? d_clamp[4:0] : grid_y;
                            interior_reg <= ({1'b0, grid_x} < d_clamp) &&
                                            ({1'b0, grid_y} < d_clamp);
                            corner_reg   <= 2'd0;
                            state_reg    <= S_SETUP;
                        end
                    end
                end
                S_SETUP:
                begin
                    p_reg[0]  <= pt.x;
                    p_reg[1]  <= pt.y;
                    p_reg[2]  <= pt.z;
                    n2s_reg   <= n2;
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    step_reg  <= 6'(SQRT_STEPS - 1);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    n2s_reg <= {n2s_reg[N2_W-3:0], 2'b00};
                    if (srem_sh >= strial)
                    begin
                        srem_reg <= srem_sh - strial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= srem_sh;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    if (step_reg == 6'd0)
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= S_DIVI;
                    end
                    else
                        step_reg <= step_reg - 6'd1;
                end
                S_DIVI:
                begin
                    // Hold a zero length at one; rounded quotient is (m*2^33 + L) / 2L.
                    if (root_reg == '0)
                        len_reg <= ROOT_W'(1);
                    else
                        len_reg <= root_reg;
                    divd_reg  <= {2'b00, pc_abs[4:0], (DIVD_W - 7)'(0)} +
                                 DIVD_W'((root_reg == '0) ? ROOT_W'(1) : root_reg);
                    neg_reg   <= pc[7];
                    drem_reg  <= '0;
                    q_reg     <= '0;
                    step_reg  <= 6'(DIV_STEPS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    divd_reg <= {divd_reg[DIVD_W-2:0], 1'b0};
                    if (drem_sh >= dvsr)
                    begin
                        drem_reg <= drem_sh - dvsr;
                        q_reg    <= {q_reg[16:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh;
                        q_reg    <= {q_reg[16:0], 1'b0};
                    end
                    if (step_reg == 6'd0)
                        state_reg <= S_MUL1;
                    else
                        step_reg <= step_reg - 6'd1;
                end
                S_MUL1:
                begin
                    prod_reg  <= mul_out[33:0];
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    pm_reg    <= pm_sum[32:8];
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    prod_reg  <= mul_out[33:0];
                    state_reg <= S_MUL4;
                end
                S_MUL4:
                begin
                    pos_reg[comp_reg] <= neg_reg ? pos_t'(-pm_ext) : pos_t'(pm_ext);
                    key_reg[comp_reg] <= neg_reg ? key_t'(-km_ext) : km_ext;
                    if (comp_reg == 2'd2)
                    begin
                        addr_reg  <= '0;
                        state_reg <= S_SRCH;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_DIVI;
                    end
                end
                S_SRCH:
                begin
                    if (addr_reg >= count_reg)
                        state_reg <= S_MISS;
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (key_hit)
                    begin
                        idx_reg[corner_reg]  <= addr_reg[IDX_W-1:0];
                        full_reg[corner_reg] <= 1'b0;
                        state_reg            <= S_NEXT;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + CNT_W'(1);
                        state_reg <= S_SRCH;
                    end
                end
                S_MISS:
                begin
                    if (count_reg < CNT_W'(MAX_VERTICES))
                    begin
                        idx_reg[corner_reg]  <= count_reg[IDX_W-1:0];
                        full_reg[corner_reg] <= 1'b0;
                        count_reg            <= count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        idx_reg[corner_reg]  <= '0;
                        full_reg[corner_reg] <= 1'b1;
                    end
                    state_reg <= S_EMITV;
                end
                S_EMITV:
                begin
                    if (out_free)
                    begin
                        kind_reg       <= KIND_VERTEX;
                        out_pos_reg[0] <= pos_reg[0];
                        out_pos_reg[1] <= pos_reg[1];
                        out_pos_reg[2] <= pos_reg[2];
                        out_a_reg      <= idx_reg[corner_reg];
                        out_b_reg      <= '0;
                        out_c_reg      <= '0;
                        out_full_reg   <= full_reg[corner_reg];
                        out_last_reg   <= !interior_reg;
                        state_reg      <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (!interior_reg)
                        state_reg <= S_IDLE;
                    else if (corner_reg == 2'd3)
                        state_reg <= S_TRI1;
                    else
                    begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= S_SETUP;
                    end
                end
                S_TRI1:
                begin
                    if (out_free)
                    begin
                        kind_reg       <= KIND_TRIANGLE;
                        out_pos_reg[0] <= '0;
                        out_pos_reg[1] <= '0;
                        out_pos_reg[2] <= '0;
                        out_a_reg      <= idx_reg[0];
                        out_b_reg      <= idx_reg[3];
                        out_c_reg      <= idx_reg[2];
                        out_full_reg   <= full_reg[0] || full_reg[3] || full_reg[2];
                        out_last_reg   <= 1'b0;
                        state_reg      <= S_TRI2;
                    end
                end
                S_TRI2:
                begin
                    if (out_free)
                    begin
                        kind_reg       <= KIND_TRIANGLE;
                        out_pos_reg[0] <= '0;
                        out_pos_reg[1] <= '0;
                        out_pos_reg[2] <= '0;
                        out_a_reg      <= idx_reg[0];
                        out_b_reg      <= idx_reg[1];
                        out_c_reg      <= idx_reg[3];
                        out_full_reg   <= full_reg[0] || full_reg[1] || full_reg[3];
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign kind       = kind_reg;
    assign pos_x      = out_pos_reg[0];
    assign pos_y      = out_pos_reg[1];
    assign pos_z      = out_pos_reg[2];
    assign index_a    = out_a_reg;
    assign index_b    = out_b_reg;
    assign index_c    = out_c_reg;
    assign table_full = out_full_reg;
    assign last       = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above table depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && kind_reg == KIND_VERTEX && out_full_reg) |-> (out_a_reg == '0))
        else $error("unstored vertex carries a nonzero index");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (len_reg != '0))
        else $error("divide started with zero length");

    a_tri_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRI2 && out_free) |=> (res_valid_reg && out_last_reg))
        else $error("second triangle not marked last");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the cube-sphere mesh builder: random and directed grid points.
module testbench;
    import csmb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       cmd;
        logic [2:0] face;
        logic [4:0] gx;
        logic [4:0] gy;
    } point_req_t;

    typedef struct {
        logic kind;
        pos_t px;
        pos_t py;
        pos_t pz;
        idx_t ia;
        idx_t ib;
        idx_t ic;
        logic full;
        logic last;
    } mesh_rec_t;

    localparam int SETTLE_CYCLES = 3000;

    localparam int AX_UP[6][3] = '{'{0,1,0}, '{0,-1,0}, '{-1,0,0}, '{1,0,0}, '{0,0,1}, '{0,0,-1}};
    localparam int AX_A[6][3]  = '{'{1,0,0}, '{-1,0,0}, '{0,0,-1}, '{0,0,1}, '{0,1,0}, '{0,-1,0}};
    localparam int AX_B[6][3]  = '{'{0,0,-1}, '{0,0,-1}, '{0,-1,0}, '{0,-1,0}, '{-1,0,0},
                                   '{-1,0,0}};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        pt_valid = 1'b0;
    logic        pt_stall;
    logic        cmd = CMD_POINT;
    logic [2:0]  face = '0;
    logic [4:0]  grid_x = '0;
    logic [4:0]  grid_y = '0;
    logic        res_valid;
    logic        res_stall = 1'b1;
    logic        kind;
    pos_t        pos_x, pos_y, pos_z;
    idx_t        index_a, index_b, index_c;
    logic        table_full;
    logic        last;

    cube_sphere_mesh_builder uut (.*);

    point_req_t pending_points[$];
    mesh_rec_t  expected_recs[$];
    int         errors = 0;

    // predictor state
    int   cur_res = 16;
    int   cur_rad = 256;
    key_t key_x_tab[MAX_VERTICES];
    key_t key_y_tab[MAX_VERTICES];
    key_t key_z_tab[MAX_VERTICES];
    int   vcount = 0;

    initial forever #2 clk = ~clk;

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic longint unsigned root_q(longint unsigned n2);
        longint unsigned rem, root, pair, trial;
        rem = 0;
        root = 0;
        for (int i = 9 + FRAC_BITS; i >= 0; i--) begin
            pair = (i >= FRAC_BITS) ? ((n2 >> (2 * (i - FRAC_BITS))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    task automatic place_corner(input int f, input int x, input int y, input int r,
                                output pos_t pos[3], output key_t key[3]);
        longint p[3];
        longint unsigned n2, len, m, u, pm, km;
        int d;
        d = r - 1;
        n2 = 0;
        for (int c = 0; c < 3; c++) begin
            p[c] = d * AX_UP[f][c] + (2 * x - d) * AX_A[f][c] + (2 * y - d) * AX_B[f][c];
            n2 = n2 + p[c] * p[c];
        end
        len = root_q(n2);
        if (len == 0)
            len = 1;
        for (int c = 0; c < 3; c++) begin
            m = (p[c] < 0) ? -p[c] : p[c];
            u = ((m << (2 * FRAC_BITS)) * 2 + len) / (2 * len);
            pm = (u * cur_rad * 2 + 256) / 512;
            km = (pm * 4 * r * 2 + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
            pos[c] = (p[c] < 0) ? -pos_t'(pm) : pos_t'(pm);
            key[c] = (p[c] < 0) ? -key_t'(km) : key_t'(km);
        end
    endtask

    // Work out the records one accepted request causes and queue them.
    task automatic predict_mesh(input point_req_t rq);
        mesh_rec_t recs[$];
        mesh_rec_t rec;
        pos_t pos[3];
        key_t key[3];
        idx_t idx[4];
        logic full[4];
        logic hit;
        int r, gx, gy, n;
        logic interior;
        if (rq.cmd == CMD_CLEAR) begin
            vcount = 0;
            return;
        end
        if (rq.face > 5)
            return;
        r = cur_res < 2 ? 2 : (cur_res > MAX_RESOLUTION ? MAX_RESOLUTION : cur_res);
        gx = rq.gx > r - 1 ? r - 1 : rq.gx;
        gy = rq.gy > r - 1 ? r - 1 : rq.gy;
        interior = gx < r - 1 && gy < r - 1;
        n = interior ? 4 : 1;
        for (int i = 0; i < n; i++) begin
            place_corner(rq.face, gx + (i & 1), gy + (i >> 1), r, pos, key);
            hit = 1'b0;
            full[i] = 1'b0;
            for (int k = 0; k < vcount && !hit; k++) begin
                if (key_x_tab[k] == key[0] && key_y_tab[k] == key[1] && key_z_tab[k] == key[2])
                begin
                    hit = 1'b1;
                    idx[i] = idx_t'(k);
                end
            end
            if (!hit) begin
                if (vcount >= MAX_VERTICES) begin
                    idx[i] = '0;
                    full[i] = 1'b1;
                end
                else begin
                    key_x_tab[vcount] = key[0];
                    key_y_tab[vcount] = key[1];
                    key_z_tab[vcount] = key[2];
                    idx[i] = idx_t'(vcount);
                    vcount++;
                end
                rec = '{KIND_VERTEX, pos[0], pos[1], pos[2], idx[i], '0, '0, full[i], 1'b0};
                recs = {recs, rec};
            end
        end
        if (interior) begin
            rec = '{KIND_TRIANGLE, '0, '0, '0, idx[0], idx[3], idx[2],
                    full[0] | full[3] | full[2], 1'b0};
            recs = {recs, rec};
            rec = '{KIND_TRIANGLE, '0, '0, '0, idx[0], idx[1], idx[3],
                    full[0] | full[1] | full[3], 1'b0};
            recs = {recs, rec};
        end
        if (recs.size() > 0)
            recs[recs.size() - 1].last = 1'b1;
        expected_recs = {expected_recs, recs};
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    // Request driver.
    int send_gap = 0;
    always @(posedge clk)
    begin
        point_req_t nx;
        logic       busy;
        if (rst_n)
        begin
            busy = pt_valid && pt_stall;
            if (pt_valid && !pt_stall)
                predict_mesh('{cmd, face, grid_x, grid_y});
            if (!busy)
            begin
                if (send_gap > 0 || pending_points.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                    pt_valid <= 1'b0;
                end
                else
                begin
                    nx = pending_points.pop_front();
                    cmd <= nx.cmd;
                    face <= nx.face;
                    grid_x <= nx.gx;
                    grid_y <= nx.gy;
                    pt_valid <= 1'b1;
                    send_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                end
            end
        end
    end

    // Result monitor with random stall.
    int stall_left = 0;
    always @(posedge clk)
    begin
        mesh_rec_t ex;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_recs.size() == 0)
                begin
                    $display("%0t: unexpected record kind=%0b a=%0d", $realtime, kind, index_a);
                    errors++;
                end
                else
                begin
                    ex = expected_recs.pop_front();
                    if (ex.kind !== kind || ex.px !== pos_x || ex.py !== pos_y
                        || ex.pz !== pos_z || ex.ia !== index_a || ex.ib !== index_b
                        || ex.ic !== index_c || ex.full !== table_full || ex.last !== last)
                    begin
                        $display("%0t: mismatch expected k=%0b p=(%0d,%0d,%0d) i=(%0d,%0d,%0d) f=%0b l=%0b",
                                 $realtime, ex.kind, ex.px, ex.py, ex.pz, ex.ia, ex.ib, ex.ic,
                                 ex.full, ex.last);
                        $display("%0t:          actual   k=%0b p=(%0d,%0d,%0d) i=(%0d,%0d,%0d) f=%0b l=%0b",
                                 $realtime, kind, pos_x, pos_y, pos_z, index_a, index_b,
                                 index_c, table_full, last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else if ($urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                stall_left <= gap_len();
            end
            else
                res_stall <= 1'b0;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || pt_valid || expected_recs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_RESOLUTION)
            cur_res = val[5:0];
        else
            cur_res = cur_res;
        if (idx == REG_RADIUS)
            cur_rad = val;
    endtask

    task automatic queue_point(input logic c, input int f, input int x, input int y);
        point_req_t rq;
        rq = '{c, 3'(f), 5'(x), 5'(y)};
        pending_points = {pending_points, rq};
    endtask

    task automatic queue_random(input int count);
        int r;
        r = cur_res < 2 ? 2 : (cur_res > MAX_RESOLUTION ? MAX_RESOLUTION : cur_res);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 14) == 0)
                queue_point(CMD_CLEAR, $urandom_range(0, 7), $urandom_range(0, 31),
                            $urandom_range(0, 31));
            else if ($urandom_range(0, 19) == 0)
                queue_point(CMD_POINT, $urandom_range(6, 7), $urandom_range(0, 31),
                            $urandom_range(0, 31));
            else if ($urandom_range(0, 3) == 0)
                queue_point(CMD_POINT, $urandom_range(0, 5), $urandom_range(0, 31),
                            $urandom_range(0, 31));
            else
                queue_point(CMD_POINT, $urandom_range(0, 5), $urandom_range(0, r - 1),
                            $urandom_range(0, r - 1));
        end
        // keep the key table short so the search stays quick
        queue_point(CMD_CLEAR, 0, 0, 0);
    endtask

    initial begin
        int res_set[7];
        int rad_set[7];
        res_set = '{16, 2, 32, 0, 63, 5, 3};
        rad_set = '{256, 1, 65535, 300, 65535, 0, 128};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, faces, corners, saturation, hits and clear
        for (int f = 0; f < 8; f++)
            queue_point(CMD_POINT, f, 0, 0);
        queue_point(CMD_POINT, 0, 0, 0);
        queue_point(CMD_POINT, 3, 31, 31);
        queue_point(CMD_POINT, 3, 15, 15);
        queue_point(CMD_POINT, 4, 15, 0);
        queue_point(CMD_POINT, 5, 0, 20);
        queue_point(CMD_POINT, 2, 14, 14);
        queue_point(CMD_POINT, 2, 15, 14);
        queue_point(CMD_CLEAR, 5, 31, 31);
        queue_point(CMD_POINT, 1, 7, 9);
        queue_point(CMD_POINT, 1, 8, 9);
        queue_point(CMD_CLEAR, 0, 0, 0);
        wait_drained();

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_RESOLUTION, 16'(res_set[ph]));
            write_reg(REG_RADIUS, 16'(rad_set[ph] == 0 ? $urandom_range(1, 65535) : rad_set[ph]));
            queue_random(55);
            wait_drained();
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/csmb_pkg.sv
hw/rtl/cube_sphere_mesh_builder.sv
dv/testbench.sv
